[rtl/core/qat_pkg.sv]
// Shared types, result kinds, character codes and the UTF-8 encoder for the tokenizer.
package qat_pkg;

    localparam int COUNT_WIDTH_DEF = 16;
    localparam int QUEUE_DEPTH_DEF = 4;
    localparam int MAX_RESULTS     = 6;
    localparam int IDX_W           = 16;

    // Result kinds carried on m_tuser
    localparam logic [1:0] KIND_DATA   = 2'd0;
    localparam logic [1:0] KIND_WORD   = 2'd1;
    localparam logic [1:0] KIND_END    = 2'd2;
    localparam logic [1:0] KIND_REJECT = 2'd3;

    // Register indexes
    localparam logic REG_CHECK_SPECIALS = 1'b0;
    localparam logic REG_ARRAY_MODE     = 1'b1;

    // Characters
    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_AMP    = 8'h26;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_LT     = 8'h3C;
    localparam logic [7:0] CH_GT     = 8'h3E;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_PIPE   = 8'h7C;
    localparam logic [7:0] CH_LC_A   = 8'h61;
    localparam logic [7:0] CH_LC_B   = 8'h62;
    localparam logic [7:0] CH_LC_E   = 8'h65;
    localparam logic [7:0] CH_LC_F   = 8'h66;
    localparam logic [7:0] CH_LC_N   = 8'h6E;
    localparam logic [7:0] CH_LC_R   = 8'h72;
    localparam logic [7:0] CH_LC_T   = 8'h74;
    localparam logic [7:0] CH_LC_U   = 8'h75;
    localparam logic [7:0] CH_LC_V   = 8'h76;

    localparam logic [7:0] CTL_BEL = 8'h07;
    localparam logic [7:0] CTL_BS  = 8'h08;
    localparam logic [7:0] CTL_TAB = 8'h09;
    localparam logic [7:0] CTL_LF  = 8'h0A;
    localparam logic [7:0] CTL_VT  = 8'h0B;
    localparam logic [7:0] CTL_FF  = 8'h0C;
    localparam logic [7:0] CTL_CR  = 8'h0D;
    localparam logic [7:0] CTL_ESC = 8'h1B;

    // All results caused by one input byte
    typedef struct packed {
        logic [2:0]                  cnt;
        logic [IDX_W-1:0]            idx;
        logic [MAX_RESULTS-1:0][1:0] kind;
        logic [MAX_RESULTS-1:0][7:0] data;
    } bundle_t;

    typedef struct packed {
        logic [2:0]      len;
        logic [3:0][7:0] bytes;
    } utf8_t;

    function automatic utf8_t utf8_encode(input logic [23:0] v);
        utf8_t r;
        r.bytes = '0;
        if (v <= 24'h00007F) begin
            r.len      = 3'd1;
            r.bytes[0] = v[7:0];
        end else if (v <= 24'h0007FF) begin
            r.len      = 3'd2;
            r.bytes[0] = {3'b110, v[10:6]};
            r.bytes[1] = {2'b10, v[5:0]};
        end else if (v <= 24'h00FFFF) begin
            r.len      = 3'd3;
            r.bytes[0] = {4'b1110, v[15:12]};
            r.bytes[1] = {2'b10, v[11:6]};
            r.bytes[2] = {2'b10, v[5:0]};
        end else begin
            r.len      = 3'd4;
            r.bytes[0] = 8'hF0 | {2'b00, v[23:18]};
            r.bytes[1] = {2'b10, v[17:12]};
            r.bytes[2] = {2'b10, v[11:6]};
            r.bytes[3] = {2'b10, v[5:0]};
        end
        return r;
    endfunction

endpackage

[rtl/core/qat_front.sv]
// Front end: parse state, config registers, turns each byte into a bundle of results.
module qat_front
    import qat_pkg::*;
#(
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       cfg_we,
    input  logic       cfg_index,
    input  logic       cfg_data,
    input  logic       in_fire,
    input  logic [7:0] in_byte,
    output logic       push,
    output bundle_t    push_bundle
);

    typedef enum logic [1:0] {QC_BETWEEN, QC_WORD, QC_SINGLE, QC_DOUBLE} qctx_t;
    typedef enum logic [2:0] {ESC_NONE, ESC_BSLASH, ESC_U, ESC_BRACE, ESC_SHORT} esc_t;

    qctx_t                  qctx_reg, qctx_next;
    esc_t                   esc_reg, esc_next;
    logic [2:0]             hexcnt_reg, hexcnt_next;
    logic [23:0]            hexval_reg, hexval_next;
    logic [COUNT_WIDTH-1:0] wcnt_reg, wcnt_next;
    logic                   rej_reg, rej_next;
    logic                   check_reg, array_reg;

    logic       dig_ok;
    logic [3:0] dig;

    always_comb begin
        dig_ok = 1'b1;
        dig    = 4'd0;
        if (in_byte >= 8'h30 && in_byte <= 8'h39)
            dig = 4'(in_byte - 8'h30);
        else if (in_byte >= 8'h61 && in_byte <= 8'h66)
            dig = 4'(in_byte - 8'h57);
        else if (in_byte >= 8'h41 && in_byte <= 8'h46)
            dig = 4'(in_byte - 8'h37);
        else
            dig_ok = 1'b0;
    end

    always_comb begin
        logic [2:0]             n;
        logic                   do_cp;
        logic                   do_plain;
        logic [23:0]            cpv;
        utf8_t                  enc;
        qctx_t                  q;
        logic [COUNT_WIDTH-1:0] wupd;
        logic [2:0]             hc_inc;
        logic [23:0]            hv_sh;
        bundle_t                b;

        n        = 3'd0;
        do_cp    = 1'b0;
        do_plain = 1'b0;
        cpv      = 24'd0;
        q        = qctx_reg;
        wupd     = wcnt_reg;
        hc_inc   = hexcnt_reg + 3'd1;
        hv_sh    = {hexval_reg[19:0], dig};
        b        = '0;

        qctx_next   = qctx_reg;
        esc_next    = esc_reg;
        hexcnt_next = hexcnt_reg;
        hexval_next = hexval_reg;
        rej_next    = rej_reg;

        if (in_byte == CH_NUL) begin
            if (!rej_reg) begin
                if (esc_reg == ESC_BSLASH) begin
                    b.kind[n] = KIND_DATA; b.data[n] = CH_BSLASH; n = n + 3'd1;
                end else if (esc_reg != ESC_NONE && hexcnt_reg != 3'd0) begin
                    do_cp = 1'b1;
                    cpv   = hexval_reg;
                end
            end
        end else if (!rej_reg) begin
            unique case (esc_reg)
                ESC_BSLASH: begin
                    esc_next = ESC_NONE;
                    unique case (in_byte)
                        CH_LC_A: begin b.kind[n] = KIND_DATA; b.data[n] = CTL_BEL; n = n + 3'd1; end
                        CH_LC_B: begin b.kind[n] = KIND_DATA; b.data[n] = CTL_BS;  n = n + 3'd1; end
                        CH_LC_E: begin b.kind[n] = KIND_DATA; b.data[n] = CTL_ESC; n = n + 3'd1; end
                        CH_LC_F: begin b.kind[n] = KIND_DATA; b.data[n] = CTL_FF;  n = n + 3'd1; end
                        CH_LC_N: begin b.kind[n] = KIND_DATA; b.data[n] = CTL_LF;  n = n + 3'd1; end
                        CH_LC_R: begin b.kind[n] = KIND_DATA; b.data[n] = CTL_CR;  n = n + 3'd1; end
                        CH_LC_T: begin b.kind[n] = KIND_DATA; b.data[n] = CTL_TAB; n = n + 3'd1; end
                        CH_LC_V: begin b.kind[n] = KIND_DATA; b.data[n] = CTL_VT;  n = n + 3'd1; end
                        CH_LC_U: begin
                            esc_next    = ESC_U;
                            hexcnt_next = 3'd0;
                            hexval_next = 24'd0;
                        end
                        default: begin
                            b.kind[n] = KIND_DATA; b.data[n] = in_byte; n = n + 3'd1;
                        end
                    endcase
                end
                ESC_U: begin
                    if (in_byte == CH_LBRACE) begin
                        esc_next = ESC_BRACE;
                    end else if (dig_ok) begin
                        esc_next    = ESC_SHORT;
                        hexcnt_next = 3'd1;
                        hexval_next = {20'd0, dig};
                    end else begin
                        esc_next = ESC_NONE;
                        do_cp    = 1'b1;
                        do_plain = 1'b1;
                    end
                end
                ESC_BRACE: begin
                    if (dig_ok && hexcnt_reg < 3'd6) begin
                        hexval_next = hv_sh;
                        hexcnt_next = hc_inc;
                    end else begin
                        esc_next = ESC_NONE;
                        do_cp    = 1'b1;
                        cpv      = hexval_reg;
                    end
                end
                ESC_SHORT: begin
                    if (dig_ok) begin
                        hexval_next = hv_sh;
                        hexcnt_next = hc_inc;
                        if (hc_inc >= 3'd4) begin
                            esc_next = ESC_NONE;
                            do_cp    = 1'b1;
                            cpv      = hv_sh;
                        end
                    end else begin
                        esc_next = ESC_NONE;
                        do_cp    = 1'b1;
                        cpv      = hexval_reg;
                        do_plain = 1'b1;
                    end
                end
                default: begin
                    esc_next = ESC_NONE;
                    do_plain = 1'b1;
                end
            endcase
        end

        enc = utf8_encode(cpv);
        if (do_cp) begin
            for (int i = 0; i < 4; i++) begin
                if (3'(i) < enc.len) begin
                    b.kind[n] = KIND_DATA; b.data[n] = enc.bytes[i]; n = n + 3'd1;
                end
            end
        end

        if (do_plain) begin
            if ((q == QC_BETWEEN || q == QC_WORD) &&
                (in_byte == CH_SPACE || in_byte == CH_TAB)) begin
                q = QC_BETWEEN;
            end else begin
                if (q == QC_BETWEEN) begin
                    q = QC_WORD;
                    if (wcnt_reg != '1)
                        wupd = wcnt_reg + 1'b1;
                    b.kind[n] = KIND_WORD;
                    b.data[n] = (wcnt_reg != '0 && !array_reg) ? CH_SPACE : CH_NUL;
                    n = n + 3'd1;
                end
                if ((in_byte == CH_SQUOTE || in_byte == CH_DQUOTE) && q == QC_WORD) begin
                    q = (in_byte == CH_SQUOTE) ? QC_SINGLE : QC_DOUBLE;
                end else if ((q == QC_SINGLE && in_byte == CH_SQUOTE) ||
                             (q == QC_DOUBLE && in_byte == CH_DQUOTE)) begin
                    q = QC_WORD;
                end else if (in_byte == CH_BSLASH) begin
                    esc_next = ESC_BSLASH;
                end else if (check_reg && q == QC_WORD &&
                             (in_byte == CH_DOLLAR || in_byte == CH_AMP ||
                              in_byte == CH_PIPE || in_byte == CH_LT ||
                              in_byte == CH_GT)) begin
                    rej_next  = 1'b1;
                    b.kind[n] = KIND_REJECT; b.data[n] = CH_NUL; n = n + 3'd1;
                end else begin
                    b.kind[n] = KIND_DATA; b.data[n] = in_byte; n = n + 3'd1;
                end
            end
            qctx_next = q;
        end

        wcnt_next = wupd;
        b.idx     = IDX_W'(wupd);

        if (in_byte == CH_NUL) begin
            b.kind[n]   = KIND_END; b.data[n] = CH_NUL; n = n + 3'd1;
            qctx_next   = QC_BETWEEN;
            esc_next    = ESC_NONE;
            hexcnt_next = 3'd0;
            hexval_next = 24'd0;
            wcnt_next   = '0;
            rej_next    = 1'b0;
        end

        b.cnt       = n;
        push_bundle = b;
        push        = in_fire && (n != 3'd0);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            qctx_reg   <= QC_BETWEEN;
            esc_reg    <= ESC_NONE;
            hexcnt_reg <= 3'd0;
            hexval_reg <= 24'd0;
            wcnt_reg   <= '0;
            rej_reg    <= 1'b0;
            check_reg  <= 1'b0;
            array_reg  <= 1'b1;
        end else begin
            if (in_fire) begin
                qctx_reg   <= qctx_next;
                esc_reg    <= esc_next;
                hexcnt_reg <= hexcnt_next;
                hexval_reg <= hexval_next;
                wcnt_reg   <= wcnt_next;
                rej_reg    <= rej_next;
            end
            if (cfg_we) begin
                if (cfg_index == REG_CHECK_SPECIALS)
                    check_reg <= cfg_data;
                if (cfg_index == REG_ARRAY_MODE)
                    array_reg <= cfg_data;
            end
        end
    end

endmodule

[rtl/core/qat_queue.sv]
// Small queue of result bundles between front end and output stage.
module qat_queue
    import qat_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    push,
    input  bundle_t push_bundle,
    input  logic    pop,
    output bundle_t head,
    output logic    empty,
    output logic    full
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    bundle_t          mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] cnt_reg;

    assign empty = (cnt_reg == '0);
    assign full  = (cnt_reg == FULL_CNT);
    assign head  = mem_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_bundle;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
            if (push && !pop)
                cnt_reg <= cnt_reg + 1'b1;
            else if (pop && !push)
                cnt_reg <= cnt_reg - 1'b1;
        end
    end

endmodule

[rtl/core/qat_back.sv]
// Output stage: walks the head bundle one result per cycle, while m_tready does not stall it, into the output register.
module qat_back
    import qat_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  bundle_t     head,
    input  logic        empty,
    output logic        pop,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,
    output logic        m_tlast,
    output logic [1:0]  m_tuser
);

    logic [2:0]  pos_reg;
    logic        valid_reg;
    logic [23:0] data_reg;
    logic        last_reg;
    logic [1:0]  kind_reg;
    logic        load;
    logic        at_end;

    assign load   = !empty && (!valid_reg || m_tready);
    assign at_end = (pos_reg == head.cnt - 3'd1);
    assign pop    = load && at_end;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg   <= 3'd0;
            valid_reg <= 1'b0;
        end else begin
            if (load) begin
                valid_reg <= 1'b1;
                pos_reg   <= at_end ? 3'd0 : pos_reg + 3'd1;
            end else if (m_tready) begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            data_reg <= {head.idx, head.data[pos_reg]};
            kind_reg <= head.kind[pos_reg];
            last_reg <= at_end;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;
    assign m_tlast  = last_reg;
    assign m_tuser  = kind_reg;

endmodule

[rtl/core/quoted_argument_tokenizer_unit.sv]
// Shell-style argument tokenizer: bytes in, content/word-start/end/reject results out.
// Path: the results of an accepted byte pass through the queue, then the output register, to m_*.
// Throughput: one byte per cycle while each byte yields at most one result and m_tready is high;
// a byte that yields several results (UTF-8 escapes, word start plus content) holds the output
// port until all are sent, and a queue of QUEUE_DEPTH bundles lets the input keep running.
// Reset (aresetn low, synchronous): parse state and queue cleared, check_specials=0, array_mode=1.
module quoted_argument_tokenizer_unit
    import qat_pkg::*;
#(
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF,
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] in_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [7:0] out_byte, [23:8] word_index
    output logic        m_tlast,
    output logic [1:0]  m_tuser,   // [1:0] kind
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic        cfg_data
);

    bundle_t push_bundle, head;
    logic    push, pop, empty, full, in_fire;

    assign s_tready = !full;
    assign in_fire  = s_tvalid && s_tready;

    qat_front #(.COUNT_WIDTH(COUNT_WIDTH)) u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_fire     (in_fire),
        .in_byte     (s_tdata),
        .push        (push),
        .push_bundle (push_bundle)
    );

    qat_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .push        (push),
        .push_bundle (push_bundle),
        .pop         (pop),
        .head        (head),
        .empty       (empty),
        .full        (full)
    );

    qat_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .head     (head),
        .empty    (empty),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

endmodule

[rtl/core/qat_checker.sv]
// Port-level checks on the tokenizer output stream, bound to the top level.
module qat_checker
    import qat_pkg::*;
(
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [23:0] m_tdata,
    input logic        m_tlast,
    input logic [1:0]  m_tuser
);

    a_reset_idle: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("output valid right after reset");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
            && $stable(m_tlast))
        else $error("stalled item changed");

    a_end_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == KIND_END |-> m_tlast && m_tdata[7:0] == CH_NUL)
        else $error("end result not last or nonzero byte");

    a_reject_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == KIND_REJECT |-> m_tlast && m_tdata[7:0] == CH_NUL)
        else $error("reject result not last or nonzero byte");

endmodule

bind quoted_argument_tokenizer_unit qat_checker u_qat_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
);
